FILE: rtl/ocn_pkg.sv
// Shared constants, codes and controller/datapath interface types for the corner node unit.
package ocn_pkg;

  localparam int GRID_W  = 64;
  localparam int GRID_H  = 64;
  localparam int COORD_W = 6;
  localparam int EXT_W   = 7;
  localparam int ROW_AW  = 6;
  localparam int CNT_W   = 7;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_PAINT = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [1:0] CORNER_LAST = 2'd3;

  typedef struct packed {
    logic             load;
    logic             clear;
    logic             rd_row;
    logic             wr_row;
    logic             query;
    logic             cap_row;
    logic             emit;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic paint_done;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/ocn_grid_mem.sv
// Occupancy row memory with per-row valid bits, registered read.
module ocn_grid_mem (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  logic                        rd_en,
  input  logic [ocn_pkg::ROW_AW-1:0]  rd_addr,
  input  logic                        wr_en,
  input  logic [ocn_pkg::ROW_AW-1:0]  wr_addr,
  input  logic [ocn_pkg::GRID_W-1:0]  wr_data,
  output logic [ocn_pkg::GRID_W-1:0]  rd_data
);
  import ocn_pkg::*;

  logic [GRID_W-1:0] mem [GRID_H];
  logic [GRID_H-1:0] row_valid;
  logic [GRID_W-1:0] rd_q;
  logic              rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= row_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

FILE: rtl/ocn_ctrl.sv
// Sequencer for clear, paint and corner query words.
module ocn_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    action,
  output ocn_pkg::cmd_t cmd,
  input  ocn_pkg::sts_t sts
);
  import ocn_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PRD  = 5'b00010,
    S_PWR  = 5'b00100,
    S_QRY  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.cnt    = cnt;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cnt_next = '0;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (action)
            ACT_CLEAR: cmd.clear = 1'b1;
            ACT_PAINT: state_next = S_PRD;
            ACT_QUERY: state_next = S_QRY;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_PRD: begin
        if (sts.paint_done) begin
          state_next = S_IDLE;
        end else begin
          cmd.rd_row = 1'b1;
          state_next = S_PWR;
        end
      end
      S_PWR: begin
        cmd.wr_row = 1'b1;
        cnt_next   = cnt + 1'b1;
        state_next = S_PRD;
      end
      S_QRY: begin
        cmd.query   = 1'b1;
        cmd.rd_row  = (cnt[2] == 1'b0);
        cmd.cap_row = (cnt != '0);
        if (cnt[2]) begin
          cnt_next   = '0;
          state_next = S_EMIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (cnt[1:0] == CORNER_LAST) begin
            cnt_next   = '0;
            state_next = S_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

endmodule

FILE: rtl/ocn_dpath.sv
// Datapath: size registers, grid memory, paint masks, corner checks and output register.
module ocn_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic                        cfg_index,
  input  logic [ocn_pkg::EXT_W-1:0]   cfg_data,
  input  logic [ocn_pkg::COORD_W-1:0] obst_x,
  input  logic [ocn_pkg::COORD_W-1:0] obst_y,
  input  logic [ocn_pkg::EXT_W-1:0]   obst_nx,
  input  logic [ocn_pkg::EXT_W-1:0]   obst_ny,
  input  ocn_pkg::cmd_t               cmd,
  output ocn_pkg::sts_t               sts,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [ocn_pkg::COORD_W-1:0] node_x,
  output logic [ocn_pkg::COORD_W-1:0] node_y,
  output logic [1:0]                  corner,
  output logic                        found,
  output logic                        last
);
  import ocn_pkg::*;

  logic [EXT_W-1:0]   grid_width, grid_height;
  logic [EXT_W-1:0]   eff_w, eff_h;
  logic [COORD_W-1:0] x, y;
  logic [EXT_W-1:0]   nx, ny;
  logic [GRID_W-1:0]  r_ym1, r_y, r_yam1, r_ya;

  logic signed [8:0]  xs, ys, x_m1, y_m1, xa, ya, xa_m1, ya_m1;
  logic [EXT_W:0]     prow, xend;
  logic [EXT_W-1:0]   hi;
  logic [GRID_W-1:0]  mask, rd_data;
  logic [ROW_AW-1:0]  rd_addr;
  logic signed [8:0]  qrow;
  logic [1:0]         k, cap_sel;
  logic signed [8:0]  cx, cy, ax, by;
  logic [GRID_W-1:0]  crow, brow;
  logic               ok;

  function automatic logic [GRID_W-1:0] ones_below(input logic [EXT_W-1:0] n);
    logic [GRID_W-1:0] one;
    one = GRID_W'(1);
    if (n >= EXT_W'(GRID_W)) begin
      return '1;
    end
    return (one << n[ROW_AW-1:0]) - one;
  endfunction

  function automatic logic in_grid(input logic signed [8:0] px, input logic signed [8:0] py,
                                   input logic [EXT_W-1:0] w, input logic [EXT_W-1:0] h);
    return (px >= 0) && (py >= 0) && (px < $signed({2'b00, w})) && (py < $signed({2'b00, h}));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= EXT_W'(GRID_W);
      grid_height <= EXT_W'(GRID_H);
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) begin
        grid_width <= cfg_data;
      end else begin
        grid_height <= cfg_data;
      end
    end
  end

  assign eff_w = (grid_width == '0) ? EXT_W'(1) :
                 (grid_width > EXT_W'(GRID_W)) ? EXT_W'(GRID_W) : grid_width;
  assign eff_h = (grid_height == '0) ? EXT_W'(1) :
                 (grid_height > EXT_W'(GRID_H)) ? EXT_W'(GRID_H) : grid_height;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x  <= obst_x;
      y  <= obst_y;
      nx <= obst_nx;
      ny <= obst_ny;
    end
  end

  assign xs    = $signed({3'b000, x});
  assign ys    = $signed({3'b000, y});
  assign x_m1  = xs - 9'sd1;
  assign y_m1  = ys - 9'sd1;
  assign xa    = xs + $signed({2'b00, nx});
  assign ya    = ys + $signed({2'b00, ny});
  assign xa_m1 = xa - 9'sd1;
  assign ya_m1 = ya - 9'sd1;

  assign prow = {2'b00, y} + {1'b0, cmd.cnt};
  assign sts.paint_done = ({1'b0, cmd.cnt} >= {1'b0, ny}) || (prow >= {1'b0, eff_h});

  assign xend = {2'b00, x} + {1'b0, nx};
  assign hi   = (xend > {1'b0, eff_w}) ? eff_w : xend[EXT_W-1:0];
  assign mask = ones_below(hi) & ~ones_below({1'b0, x});

  always_comb begin
    case (cmd.cnt[1:0])
      2'd0:    qrow = y_m1;
      2'd1:    qrow = ys;
      2'd2:    qrow = ya_m1;
      default: qrow = ya;
    endcase
  end

  assign rd_addr = cmd.query ? qrow[ROW_AW-1:0] : prow[ROW_AW-1:0];

  ocn_grid_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .clear   (cmd.clear),
    .rd_en   (cmd.rd_row),
    .rd_addr (rd_addr),
    .wr_en   (cmd.wr_row),
    .wr_addr (prow[ROW_AW-1:0]),
    .wr_data (rd_data | mask),
    .rd_data (rd_data)
  );

  assign cap_sel = cmd.cnt[1:0] - 2'd1;

  always_ff @(posedge clk) begin
    if (cmd.cap_row) begin
      case (cap_sel)
        2'd0:    r_ym1  <= rd_data;
        2'd1:    r_y    <= rd_data;
        2'd2:    r_yam1 <= rd_data;
        default: r_ya   <= rd_data;
      endcase
    end
  end

  assign k    = cmd.cnt[1:0];
  assign cx   = k[1] ? xa : x_m1;
  assign ax   = k[1] ? xa_m1 : xs;
  assign cy   = k[0] ? ya : y_m1;
  assign by   = k[0] ? ya_m1 : ys;
  assign crow = k[0] ? r_ya : r_ym1;
  assign brow = k[0] ? r_yam1 : r_y;

  assign ok = in_grid(cx, cy, eff_w, eff_h)
              && !crow[cx[ROW_AW-1:0]]
              && !(in_grid(ax, cy, eff_w, eff_h) && crow[ax[ROW_AW-1:0]])
              && !(in_grid(cx, by, eff_w, eff_h) && brow[cx[ROW_AW-1:0]]);

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      node_x <= ok ? cx[COORD_W-1:0] : '0;
      node_y <= ok ? cy[COORD_W-1:0] : '0;
      corner <= k;
      found  <= ok;
      last   <= (k == CORNER_LAST);
    end
  end

endmodule

FILE: rtl/occupancy_grid_corner_nodes_unit.sv
// Top level of the occupancy grid corner node unit.
//
// Input channel (in_valid/in_ready) takes one word: action, obst_x, obst_y,
// obst_nx, obst_ny. Action clear frees the whole grid in the accepting cycle.
// Action paint occupies the rectangle, one grid row at a time (read the row,
// then write it back), from the accepting cycle up to a final row check.
// Action query reads four rows, then emits four result words (node_x, node_y,
// corner, found, last) through the output register, one per cycle when
// out_ready is high; last marks the fourth.
// Unused action codes are dropped.
// The output register holds a word while out_ready is low and the sequencer
// waits; the next input word is taken while the final result is still held.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 sets the grid width, index 1 the grid height.
// Reset clears the grid through per-row valid bits at once, sets both sizes to
// 64, and empties the output register.
module occupancy_grid_corner_nodes_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [ocn_pkg::EXT_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  action,
  input  logic [ocn_pkg::COORD_W-1:0] obst_x,
  input  logic [ocn_pkg::COORD_W-1:0] obst_y,
  input  logic [ocn_pkg::EXT_W-1:0]   obst_nx,
  input  logic [ocn_pkg::EXT_W-1:0]   obst_ny,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ocn_pkg::COORD_W-1:0] node_x,
  output logic [ocn_pkg::COORD_W-1:0] node_y,
  output logic [1:0]                  corner,
  output logic                        found,
  output logic                        last
);
  import ocn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ocn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .cmd      (cmd),
    .sts      (sts)
  );

  ocn_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .obst_x    (obst_x),
    .obst_y    (obst_y),
    .obst_nx   (obst_nx),
    .obst_ny   (obst_ny),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .node_x    (node_x),
    .node_y    (node_y),
    .corner    (corner),
    .found     (found),
    .last      (last)
  );

  a_busy_after_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (action == ACT_PAINT || action == ACT_QUERY)) |=> !in_ready)
    else $error("sequencer took a new word while a paint or query was pending");

  a_last_is_fourth: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (corner == CORNER_LAST))
    else $error("last flag on a result other than the fourth corner");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (node_x == '0 && node_y == '0))
    else $error("corner not found but coordinates are nonzero");

  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && $past(cmd.emit) && !$past(rst)) |-> (cmd.cnt[1:0] == $past(cmd.cnt[1:0]) + 2'd1))
    else $error("corner results out of order");

endmodule
